### rtl/slfr_pkg.sv
package slfr_pkg;

    // Per-channel half of the frame store
    localparam int BUF_DEPTH   = 512;
    localparam int STORE_AW    = $clog2(BUF_DEPTH);
    localparam int STORE_DEPTH = 2 ** (STORE_AW + 1);

    localparam int CHAN_NUM = 2;

    localparam logic [8:0]  FRAME_OVERHEAD = 9'd4;
    localparam logic [8:0]  LEN_POS        = 9'd3;
    localparam logic [7:0]  SYNC_RESET     = 8'hAA;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd50;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] PORT_NONE = 2'd0;

    localparam logic CFG_SYNC    = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic       channel;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [8:0] pos;
        logic [7:0] len;
    } t_chan;

    typedef struct packed {
        logic [15:0] timer;
        logic [8:0]  last_len;
        logic [1:0]  port;
    } t_glob;

    typedef struct packed {
        logic  chan_we;
        logic  clr_all;
        t_chan chan;
        t_glob glob;
    } t_upd;

    typedef struct packed {
        logic [8:0] write_index;
        logic       write_valid;
        logic       frame_done;
        logic [8:0] frame_length;
        logic       rx_busy;
        logic [1:0] active_port;
        logic       port_changed;
        logic       timed_out;
    } t_res;

endpackage

### rtl/slfr_in_if.sv
interface slfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic       channel;
    logic [7:0] rx_byte;

    modport source (output valid, cmd, channel, rx_byte, input ready);
    modport sink   (input valid, cmd, channel, rx_byte, output ready);
endinterface

### rtl/slfr_out_if.sv
interface slfr_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] write_index;
    logic       write_valid;
    logic       frame_done;
    logic [8:0] frame_length;
    logic       rx_busy;
    logic [1:0] active_port;
    logic       port_changed;
    logic       timed_out;

    modport source (output valid, write_index, write_valid, frame_done, frame_length,
                    rx_busy, active_port, port_changed, timed_out, input ready);
    modport sink   (input valid, write_index, write_valid, frame_done, frame_length,
                    rx_busy, active_port, port_changed, timed_out, output ready);
endinterface

### rtl/sync_length_frame_receiver_unit.sv
// Channel   Dir  Handshake        Payload
// i_item    in   valid / ready    cmd, channel, rx_byte
// o_res     out  valid / ready    write_index .. timed_out (one result per item)
// i_cfg_*   in   write enable     index 0 sync_value, index 1 timeout_ticks
//
// One item per cycle sustained unless the output stalls; results pass the work stage,
// then the output register. Channel-state RAM is read at acceptance and updated in the
// work stage; last write forwarded, so back-to-back same-channel items see fresh state.
// Reset is synchronous; state entries come up zero through per-entry valid bits,
// so there is no clearing pass. i_item.ready drops only when the work stage and
// the output register are both full and o_res.ready is low.
module sync_length_frame_receiver_unit
    import slfr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    slfr_in_if.sink      i_item,
    slfr_out_if.source   o_res,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata
);

    logic [7:0]  r_sync;
    logic [15:0] r_timeout;

    logic  r_s1_vld;
    t_item r_s1_item;
    t_glob r_glob;

    logic          r_fwd_vld;
    logic          r_fwd_addr;
    t_chan         r_fwd_data;
    logic [CHAN_NUM-1:0] r_ent_vld;
    logic [CHAN_NUM-1:0] r_stale;

    logic r_out_vld;
    t_res r_out;

    logic  accept;
    logic  s1_adv;
    t_item in_item;
    t_chan ram_rdata;
    t_chan base;
    t_chan chan_cur;
    t_upd  upd;
    t_res  res;
    logic  wr_en;

    assign in_item.cmd     = i_item.cmd;
    assign in_item.channel = i_item.channel;
    assign in_item.rx_byte = i_item.rx_byte;

    assign s1_adv       = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_item.ready = !r_s1_vld || s1_adv;
    assign accept       = i_item.valid && i_item.ready;
    assign wr_en        = s1_adv && upd.chan_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync    <= SYNC_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC:    r_sync    <= i_cfg_wdata[7:0];
                CFG_TIMEOUT: r_timeout <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    slfr_chan_ram u_chan_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_item.channel),
        .i_wdata (upd.chan),
        .i_re    (accept),
        .i_raddr (i_item.channel),
        .o_rdata (ram_rdata)
    );

    // Latest write wins over RAM data; a timeout since then zeroes the position
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_s1_item.channel)) begin
            base = r_fwd_data;
        end else if (r_ent_vld[r_s1_item.channel]) begin
            base = ram_rdata;
        end else begin
            base = '0;
        end
        chan_cur     = base;
        if (r_stale[r_s1_item.channel]) begin
            chan_cur.pos = 9'd0;
        end
    end

    slfr_step u_step (
        .i_item    (r_s1_item),
        .i_chan    (chan_cur),
        .i_glob    (r_glob),
        .i_sync    (r_sync),
        .i_timeout (r_timeout),
        .o_upd     (upd),
        .o_res     (res)
    );

    slfr_store u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_addr ({r_s1_item.channel, STORE_AW'(chan_cur.pos)}),
        .i_data (r_s1_item.rx_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_glob    <= '0;
            r_fwd_vld <= 1'b0;
            r_ent_vld <= '0;
            r_stale   <= '0;
        end else begin
            if (i_item.ready) begin
                r_s1_vld <= i_item.valid;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_glob    <= upd.glob;
                if (upd.chan_we) begin
                    r_fwd_vld                     <= 1'b1;
                    r_ent_vld[r_s1_item.channel]  <= 1'b1;
                    r_stale[r_s1_item.channel]    <= 1'b0;
                end
                if (upd.clr_all) begin
                    r_stale <= '1;
                end
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= in_item;
        end
        if (s1_adv) begin
            r_out <= res;
        end
        if (wr_en) begin
            r_fwd_addr <= r_s1_item.channel;
            r_fwd_data <= upd.chan;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.write_index  = r_out.write_index;
    assign o_res.write_valid  = r_out.write_valid;
    assign o_res.frame_done   = r_out.frame_done;
    assign o_res.frame_length = r_out.frame_length;
    assign o_res.rx_busy      = r_out.rx_busy;
    assign o_res.active_port  = r_out.active_port;
    assign o_res.port_changed = r_out.port_changed;
    assign o_res.timed_out    = r_out.timed_out;

endmodule

### rtl/slfr_chan_ram.sv
module slfr_chan_ram
    import slfr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_we,
    input  logic  i_waddr,
    input  t_chan i_wdata,
    input  logic  i_re,
    input  logic  i_raddr,
    output t_chan o_rdata
);

    t_chan r_mem [CHAN_NUM];
    t_chan r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the reading stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/slfr_store.sv
module slfr_store
    import slfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [STORE_AW:0]     i_addr,
    input  logic [7:0]            i_data
);

    // Channel number is the top address bit; each half holds one frame
    logic [7:0] r_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_data;
        end
    end

endmodule

### rtl/slfr_step.sv
module slfr_step
    import slfr_pkg::*;
(
    input  t_item       i_item,
    input  t_chan       i_chan,
    input  t_glob       i_glob,
    input  logic [7:0]  i_sync,
    input  logic [15:0] i_timeout,
    output t_upd        o_upd,
    output t_res        o_res
);

    logic       adv;
    logic [8:0] pos1;
    logic [7:0] len1;
    logic [8:0] limit;
    logic       done;
    logic [1:0] port;

    always_comb begin
        adv   = (i_chan.pos != 9'd0) || (i_item.rx_byte == i_sync);
        pos1  = i_chan.pos + {8'd0, adv};
        len1  = (pos1 == LEN_POS) ? i_item.rx_byte : i_chan.len;
        limit = {1'b0, len1} + FRAME_OVERHEAD;
        done  = (pos1 >= limit);
        port  = {1'b0, i_item.channel} + 2'd1;

        o_upd      = '0;
        o_upd.chan = i_chan;
        o_upd.glob = i_glob;
        o_res      = '0;

        if (i_item.cmd == CMD_BYTE) begin
            o_upd.chan_we     = 1'b1;
            o_upd.glob.timer  = i_timeout;
            o_res.write_index = i_chan.pos;
            o_res.write_valid = 1'b1;
            if (done) begin
                o_upd.chan          = '0;
                o_upd.glob.last_len = pos1;
                o_upd.glob.port     = port;
                o_res.frame_done    = 1'b1;
                o_res.port_changed  = (i_glob.port != port);
            end else begin
                o_upd.chan.pos = pos1;
                o_upd.chan.len = len1;
            end
            o_res.rx_busy = (o_upd.chan.pos != 9'd0);
        end else begin
            if (i_glob.timer != 16'd0) begin
                o_upd.glob.timer = i_glob.timer - 16'd1;
                // Last tick of silence drops both partial frames
                if (i_glob.timer == 16'd1) begin
                    o_upd.clr_all   = 1'b1;
                    o_res.timed_out = 1'b1;
                end
            end
            o_res.rx_busy = !o_upd.clr_all && (i_chan.pos != 9'd0);
        end

        o_res.frame_length = o_upd.glob.last_len;
        o_res.active_port  = o_upd.glob.port;
    end

endmodule

### rtl/slfr_checker.sv
module slfr_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [8:0] i_write_index,
    input  logic       i_write_valid,
    input  logic       i_frame_done,
    input  logic [8:0] i_frame_length,
    input  logic       i_rx_busy,
    input  logic [1:0] i_active_port,
    input  logic       i_port_changed,
    input  logic       i_timed_out
);

    // A stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_write_index)
            && $stable(i_frame_done) && $stable(i_frame_length) && $stable(i_rx_busy))
        else $error("result changed while stalled");

    // A finished frame leaves the channel hunting and names an active port
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_write_valid && !i_rx_busy
            && (i_active_port != 2'd0) && (i_frame_length >= 9'd4))
        else $error("frame completion inconsistent");

    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_port_changed |-> i_frame_done)
        else $error("port change without frame completion");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_timed_out |-> !i_write_valid && !i_rx_busy
            && (i_write_index == 9'd0) && !i_frame_done)
        else $error("timeout result inconsistent");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_write_index  (o_res.write_index),
    .i_write_valid  (o_res.write_valid),
    .i_frame_done   (o_res.frame_done),
    .i_frame_length (o_res.frame_length),
    .i_rx_busy      (o_res.rx_busy),
    .i_active_port  (o_res.active_port),
    .i_port_changed (o_res.port_changed),
    .i_timed_out    (o_res.timed_out)
);

### test/tb_sync_length_frame_receiver_unit.sv
module tb_sync_length_frame_receiver_unit;
    import slfr_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_SYNC;
    logic [15:0] i_cfg_wdata = 16'd0;

    // sender side regs, mirrored onto the interface
    logic        drv_valid   = 1'b0;
    logic        drv_cmd     = CMD_BYTE;
    logic        drv_channel = 1'b0;
    logic [7:0]  drv_byte    = 8'd0;
    logic        rx_ready    = 1'b0;

    slfr_in_if  in_if();
    slfr_out_if out_if();

    assign in_if.valid   = drv_valid;
    assign in_if.cmd     = drv_cmd;
    assign in_if.channel = drv_channel;
    assign in_if.rx_byte = drv_byte;
    assign out_if.ready  = rx_ready;

    sync_length_frame_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (in_if),
        .o_res       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // deframer state as the block should hold it
    logic [7:0]  sync_byte   = SYNC_RESET;
    logic [15:0] tmo_reload  = TIMEOUT_RESET;
    logic [8:0]  chan_pos [2] = '{9'd0, 9'd0};
    logic [7:0]  chan_len [2] = '{8'd0, 8'd0};
    logic [8:0]  last_len    = 9'd0;
    logic [15:0] silence_cnt = 16'd0;
    logic [1:0]  cur_port    = PORT_NONE;

    t_item tx_items[$];
    t_res  pending_status[$];
    logic [7:0] staged0[$];
    logic [7:0] staged1[$];

    int    err_count   = 0;
    logic  sender_hold = 1'b0;
    int    stall_token = 0;
    int    stall_seen  = 0;
    int    stall_left  = 0;
    int    burst_left  = 0;
    int    gap_left    = 0;
    logic [7:0] rx_phase   = 8'd0;
    logic [1:0] rx_mode    = 2'd0;
    logic [7:0] rx_pattern = 8'hA5;
    t_item drv_item;
    t_item mon_item;
    t_res  got_status;
    t_res  want_status;

    function automatic t_res deframe_step(input t_item it);
        t_res       r;
        logic [8:0] p;
        logic [1:0] port_id;
        r = '0;
        if (it.cmd == CMD_BYTE) begin
            p = chan_pos[it.channel];
            r.write_index = p;
            r.write_valid = 1'b1;
            // at position 0 only the sync byte opens a frame
            if (p != 9'd0 || it.rx_byte == sync_byte) p = p + 9'd1;
            if (p == LEN_POS) chan_len[it.channel] = it.rx_byte;
            if (p >= {1'b0, chan_len[it.channel]} + FRAME_OVERHEAD) begin
                port_id = {1'b0, it.channel} + 2'd1;
                last_len = p;
                p = 9'd0;
                chan_len[it.channel] = 8'd0;
                r.frame_done = 1'b1;
                if (cur_port != port_id) begin
                    cur_port = port_id;
                    r.port_changed = 1'b1;
                end
            end
            chan_pos[it.channel] = p;
            silence_cnt = tmo_reload;
        end else if (silence_cnt != 16'd0) begin
            silence_cnt = silence_cnt - 16'd1;
            if (silence_cnt == 16'd0) begin
                chan_pos[0] = 9'd0;
                chan_pos[1] = 9'd0;
                r.timed_out = 1'b1;
            end
        end
        r.frame_length = last_len;
        r.rx_busy      = (chan_pos[it.channel] != 9'd0);
        r.active_port  = cur_port;
        return r;
    endfunction

    task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // sender: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (drv_valid && !in_if.ready) begin
            // hold the offered item
        end else if (gap_left != 0) begin
            drv_valid <= 1'b0;
            gap_left  <= gap_left - 1;
        end else if (tx_items.size() != 0 && !sender_hold) begin
            drv_item = tx_items.pop_front();
            drv_cmd     <= drv_item.cmd;
            drv_channel <= drv_item.channel;
            drv_byte    <= drv_item.rx_byte;
            drv_valid   <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                if ($urandom_range(0, 1) == 0)
                    gap_left <= 0;
                else if ($urandom_range(0, 9) == 0)
                    gap_left <= 25;
                else
                    gap_left <= $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            drv_valid <= 1'b0;
        end
    end

    // receiver: stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            rx_phase <= rx_phase + 8'd1;
            if (rx_phase[5:0] == 6'd63) begin
                rx_mode    <= 2'($urandom_range(0, 3));
                rx_pattern <= 8'($urandom) | 8'h01;
            end
            if (stall_seen != stall_token) begin
                stall_seen <= stall_token;
                stall_left <= 300;
                rx_ready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                rx_ready   <= 1'b0;
            end else begin
                case (rx_mode)
                    2'd0: rx_ready <= 1'b1;
                    2'd1: rx_ready <= 1'($urandom_range(0, 1));
                    2'd2: rx_ready <= rx_pattern[rx_phase[2:0]];
                    default: rx_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // result check, then prediction for a newly accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && rx_ready) begin
                got_status.write_index  = out_if.write_index;
                got_status.write_valid  = out_if.write_valid;
                got_status.frame_done   = out_if.frame_done;
                got_status.frame_length = out_if.frame_length;
                got_status.rx_busy      = out_if.rx_busy;
                got_status.active_port  = out_if.active_port;
                got_status.port_changed = out_if.port_changed;
                got_status.timed_out    = out_if.timed_out;
                if (pending_status.size() == 0) begin
                    $error("result with no item outstanding");
                    err_count++;
                end else begin
                    want_status = pending_status.pop_front();
                    cmp_field("write_index", want_status.write_index, got_status.write_index);
                    cmp_field("write_valid", want_status.write_valid, got_status.write_valid);
                    cmp_field("frame_done", want_status.frame_done, got_status.frame_done);
                    cmp_field("frame_length", want_status.frame_length,
                              got_status.frame_length);
                    cmp_field("rx_busy", want_status.rx_busy, got_status.rx_busy);
                    cmp_field("active_port", want_status.active_port, got_status.active_port);
                    cmp_field("port_changed", want_status.port_changed,
                              got_status.port_changed);
                    cmp_field("timed_out", want_status.timed_out, got_status.timed_out);
                end
            end
            if (in_if.valid && in_if.ready) begin
                mon_item.cmd     = in_if.cmd;
                mon_item.channel = in_if.channel;
                mon_item.rx_byte = in_if.rx_byte;
                pending_status.push_back(deframe_step(mon_item));
            end
        end
    end

    task automatic send(input logic cmd, input logic ch, input logic [7:0] b);
        t_item it;
        it.cmd     = cmd;
        it.channel = ch;
        it.rx_byte = b;
        tx_items.push_back(it);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_SYNC)
            sync_byte = val[7:0];
        else
            tmo_reload = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (tx_items.size() != 0 || drv_valid || pending_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one frame for a channel, now and then cut short
    task automatic stage_frame(ref logic [7:0] q[$]);
        int r;
        int len;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 85)
            len = $urandom_range(0, 12);
        else if (r < 99)
            len = $urandom_range(13, 60);
        else
            len = 255;
        q.push_back(sync_byte);
        q.push_back(8'($urandom));
        q.push_back(8'(len));
        repeat (len + 1) q.push_back(8'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end
    endtask

    task automatic gen_traffic(input int n);
        int cnt;
        int r;
        int k;
        int cap;
        logic ch;
        logic [7:0] b;
        cnt = 0;
        staged0.delete();
        staged1.delete();
        if (tmo_reload == 16'd0 || tmo_reload > 16'd60)
            cap = 8;
        else
            cap = tmo_reload + 2;
        while (cnt < n) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                k = $urandom_range(1, cap);
                repeat (k) send(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom));
                cnt += k;
            end else if (r < 10) begin
                send(CMD_BYTE, 1'($urandom_range(0, 1)), 8'($urandom));
                cnt++;
            end else begin
                ch = 1'($urandom_range(0, 1));
                if (ch) begin
                    if (staged1.size() == 0) stage_frame(staged1);
                    b = staged1.pop_front();
                end else begin
                    if (staged0.size() == 0) stage_frame(staged0);
                    b = staged0.pop_front();
                end
                send(CMD_BYTE, ch, b);
                cnt++;
            end
        end
    endtask

    initial begin
        #3000000;
        $display("sync_length_frame_receiver_unit regression: fail");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: ticks with idle timer, stray bytes, short frames on both ports
        send(CMD_TICK, 1'b0, 8'hFF);
        send(CMD_TICK, 1'b1, 8'h00);
        send(CMD_BYTE, 1'b0, 8'h00);
        send(CMD_BYTE, 1'b1, 8'hFF);
        send(CMD_BYTE, 1'b0, 8'hAA);
        send(CMD_BYTE, 1'b0, 8'hFF);
        send(CMD_BYTE, 1'b0, 8'h00);
        send(CMD_BYTE, 1'b0, 8'h00);
        send(CMD_BYTE, 1'b1, 8'hAA);
        send(CMD_BYTE, 1'b0, 8'hAA);
        send(CMD_BYTE, 1'b1, 8'h5A);
        send(CMD_BYTE, 1'b0, 8'hA5);
        send(CMD_BYTE, 1'b1, 8'h01);
        send(CMD_BYTE, 1'b0, 8'h00);
        send(CMD_BYTE, 1'b1, 8'h7E);
        send(CMD_BYTE, 1'b0, 8'h81);
        send(CMD_BYTE, 1'b1, 8'h3C);
        send(CMD_TICK, 1'b0, 8'h55);
        drain();

        // receiver holds off while the sender keeps offering
        gen_traffic(300);
        repeat (30) @(negedge i_clk);
        stall_token++;
        drain();

        // one-tick timeout; a timeout leaves the old length behind
        write_reg(CFG_SYNC, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'd1);
        send(CMD_BYTE, 1'b1, 8'h00);
        send(CMD_BYTE, 1'b1, 8'h11);
        send(CMD_BYTE, 1'b1, 8'h05);
        send(CMD_TICK, 1'b1, 8'h00);
        send(CMD_TICK, 1'b1, 8'h00);
        send(CMD_BYTE, 1'b1, 8'h00);
        send(CMD_BYTE, 1'b1, 8'h22);
        send(CMD_BYTE, 1'b1, 8'h00);
        send(CMD_BYTE, 1'b1, 8'h33);
        gen_traffic(300);
        drain();

        // longest frame, then a sender pause mid-stream
        write_reg(CFG_SYNC, 16'h00FF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        send(CMD_BYTE, 1'b1, 8'hFF);
        send(CMD_BYTE, 1'b1, 8'($urandom));
        send(CMD_BYTE, 1'b1, 8'hFF);
        repeat (256) send(CMD_BYTE, 1'b1, 8'($urandom));
        gen_traffic(300);
        while (tx_items.size() > 150) @(negedge i_clk);
        sender_hold = 1'b1;
        while (drv_valid || pending_status.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        sender_hold = 1'b0;
        drain();

        // zero reload: the timer never expires
        write_reg(CFG_SYNC, 16'($urandom_range(0, 255)));
        write_reg(CFG_TIMEOUT, 16'd0);
        send(CMD_BYTE, 1'b0, sync_byte);
        send(CMD_BYTE, 1'b0, 8'h44);
        send(CMD_BYTE, 1'b0, 8'h02);
        repeat (10) send(CMD_TICK, 1'b0, 8'h00);
        send(CMD_BYTE, 1'b0, 8'h01);
        send(CMD_BYTE, 1'b0, 8'h02);
        send(CMD_BYTE, 1'b0, 8'h03);
        gen_traffic(50);
        drain();

        write_reg(CFG_SYNC, 16'($urandom_range(0, 255)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(2, 40)));
        gen_traffic(50);
        drain();
        repeat (10) @(negedge i_clk);

        if (pending_status.size() != 0)
            $error("%0d results never arrived", pending_status.size());
        if (err_count == 0 && pending_status.size() == 0)
            $display("sync_length_frame_receiver_unit regression: pass");
        else
            $display("sync_length_frame_receiver_unit regression: fail");
        $finish;
    end

endmodule
